// ===== src/ulbp_pkg.sv =====
package ulbp_pkg;

  localparam int unsigned LINE_DEPTH = 4096;
  localparam int unsigned LINE_AW    = $clog2(LINE_DEPTH);
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned GEOM_W     = 13;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned CODE_W     = 6;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  localparam logic [GEOM_W-1:0] WIDTH_RESET  = GEOM_W'(640);
  localparam logic [GEOM_W-1:0] HEIGHT_RESET = GEOM_W'(480);
  localparam logic [GEOM_W-1:0] COUNT_CAP    = GEOM_W'(4096);
  localparam logic [GEOM_W-1:0] WIDTH_CAP    =
    (LINE_DEPTH < 4096) ? GEOM_W'(LINE_DEPTH) : COUNT_CAP;

  localparam logic [CODE_W-1:0] CODE_FLAT_LOW  = CODE_W'(0);
  localparam logic [CODE_W-1:0] CODE_FLAT_HIGH = CODE_W'(57);
  localparam logic [CODE_W-1:0] NON_UNIFORM    = CODE_W'(58);

  typedef logic [PIX_W-1:0] pix_t;

  // uniform pattern index: run of k ones rotated left by r gives 1+8(k-1)+r
  function automatic logic [CODE_W-1:0] uniform_index(input logic [7:0] p);
    logic [3:0]        k;
    logic [8:0]        run_w;
    logic [7:0]        run;
    logic [15:0]       dbl;
    logic [CODE_W-1:0] res;
    logic              found;
    k     = '0;
    res   = NON_UNIFORM;
    found = 1'b0;
    for (int i = 0; i < 8; i++) begin
      k = k + 4'(p[i]);
    end
    run_w = (9'd1 << k) - 9'd1;
    run   = run_w[7:0];
    if (p == 8'h00) begin
      res = CODE_FLAT_LOW;
    end else if (p == 8'hff) begin
      res = CODE_FLAT_HIGH;
    end else begin
      for (int r = 0; r < 8; r++) begin
        dbl = {run, run} << r;
        if (!found && dbl[15:8] == p) begin
          found = 1'b1;
          res   = CODE_W'(1 + 8 * (int'(k) - 1) + r);
        end
      end
    end
    return res;
  endfunction

endpackage

// ===== src/ulbp_if.sv =====
interface ulbp_pix_if;
  logic                      valid;
  logic                      ready;
  logic [ulbp_pkg::PIX_W-1:0] pixel_value;
  logic                      frame_start;

  modport source (output valid, output pixel_value, output frame_start, input ready);
  modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

interface ulbp_code_if;
  logic                       valid;
  logic                       ready;
  logic [ulbp_pkg::CODE_W-1:0] lbp_code;
  logic [ulbp_pkg::POS_W-1:0]  center_row;
  logic [ulbp_pkg::POS_W-1:0]  center_col;
  logic                       frame_last;

  modport source (output valid, output lbp_code, output center_row, output center_col,
                  output frame_last, input ready);
  modport sink   (input valid, input lbp_code, input center_row, input center_col,
                  input frame_last, output ready);
endinterface

interface ulbp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ulbp_pkg::CFG_IDX_W-1:0] index;
  logic [ulbp_pkg::GEOM_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/uniform_lbp_pixel_coder_unit.sv =====
// a code is loaded into the output register when the pixel below-right of its centre leaves stage 1
// throughput: 1 pixel per clock while code_o is not back-pressured, one read and one write of the line memory per pixel
// the two line stores share one memory, read at accept and written back when the pixel leaves stage 1
// reset: counters and window cleared, geometry back to 640 x 480, pipeline emptied
// the line memory is not cleared; it holds nothing defined until written
module uniform_lbp_pixel_coder_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  ulbp_pix_if.sink      pix_i,
  ulbp_cfg_if.sink      cfg_i,
  ulbp_code_if.source   code_o
);

  localparam int unsigned PW = ulbp_pkg::PIX_W;
  localparam int unsigned GW = ulbp_pkg::GEOM_W;
  localparam int unsigned QW = ulbp_pkg::POS_W;
  localparam int unsigned AW = ulbp_pkg::LINE_AW;

  // configuration
  logic [GW-1:0] width_q, height_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ulbp_pkg::WIDTH_RESET;
      height_q <= ulbp_pkg::HEIGHT_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        ulbp_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_i.data;
        ulbp_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  logic [GW-1:0] w_lim, h_lim;
  always_comb begin
    w_lim = (width_q == '0) ? GW'(1) : width_q;
    if (w_lim > ulbp_pkg::WIDTH_CAP) w_lim = ulbp_pkg::WIDTH_CAP;
    h_lim = (height_q == '0) ? GW'(1) : height_q;
    if (h_lim > ulbp_pkg::COUNT_CAP) h_lim = ulbp_pkg::COUNT_CAP;
  end

  // pipeline control
  logic s1_valid_q, s1_res_q;
  logic out_valid_q;
  logic s1_adv, in_ready, accept;

  assign s1_adv   = s1_valid_q && (!s1_res_q || !out_valid_q || code_o.ready);
  assign in_ready = !s1_valid_q || s1_adv;
  assign accept   = pix_i.valid && in_ready;
  assign pix_i.ready = in_ready;

  // position counters
  logic [QW-1:0] col_q, row_q, col_d, row_d;
  logic [QW-1:0] c_cur, r_cur;
  logic [GW-1:0] c_ext, r_ext;
  logic          res_now, last_now;

  always_comb begin
    c_cur = pix_i.frame_start ? '0 : col_q;
    r_cur = pix_i.frame_start ? '0 : row_q;
    c_ext = GW'(c_cur);
    r_ext = GW'(r_cur);
    if (c_ext + GW'(1) >= w_lim) begin
      col_d = '0;
      row_d = (r_ext + GW'(1) >= h_lim) ? '0 : QW'(r_ext + GW'(1));
    end else begin
      col_d = QW'(c_ext + GW'(1));
      row_d = r_cur;
    end
    res_now  = (r_cur >= QW'(2)) && (c_cur >= QW'(2)) && (r_ext < h_lim) && (c_ext < w_lim);
    last_now = (r_ext == h_lim - GW'(1)) && (c_ext == w_lim - GW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line memory: upper row in the high byte, middle row in the low byte
  logic [2*PW-1:0] line_mem [ulbp_pkg::LINE_DEPTH];
  logic [2*PW-1:0] rd_q;
  logic [AW-1:0]   rd_addr;
  logic [2*PW-1:0] wr_data;
  logic [2*PW-1:0] fwd_data_q;
  logic            fwd_hit_q;

  assign rd_addr = c_cur[AW-1:0];

  // stage 1 registers
  ulbp_pkg::pix_t s1_px_q;
  logic [AW-1:0]  s1_addr_q;
  logic [QW-1:0]  s1_row_q, s1_col_q;
  logic           s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_res_q   <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
        s1_res_q   <= res_now;
        // write of the item ahead lands on the same edge as this read
        fwd_hit_q  <= s1_adv && (s1_addr_q == rd_addr);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
        s1_res_q   <= 1'b0;
        fwd_hit_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q       <= line_mem[rd_addr];
      fwd_data_q <= wr_data;
      s1_px_q    <= pix_i.pixel_value;
      s1_addr_q  <= rd_addr;
      s1_row_q   <= r_cur - QW'(1);
      s1_col_q   <= c_cur - QW'(1);
      s1_last_q  <= last_now;
    end
  end

  logic [2*PW-1:0] rd_eff;
  ulbp_pkg::pix_t  up_px, mid_px;

  assign rd_eff  = fwd_hit_q ? fwd_data_q : rd_q;
  assign up_px   = rd_eff[2*PW-1:PW];
  assign mid_px  = rd_eff[PW-1:0];
  assign wr_data = {mid_px, s1_px_q};

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      line_mem[s1_addr_q] <= wr_data;
    end
  end

  // 3x3 window, row-major
  ulbp_pkg::pix_t win_q [9];
  ulbp_pkg::pix_t win_d [9];

  always_comb begin
    win_d[0] = win_q[1]; win_d[1] = win_q[2]; win_d[2] = up_px;
    win_d[3] = win_q[4]; win_d[4] = win_q[5]; win_d[5] = mid_px;
    win_d[6] = win_q[7]; win_d[7] = win_q[8]; win_d[8] = s1_px_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else if (s1_adv) begin
      for (int i = 0; i < 9; i++) win_q[i] <= win_d[i];
    end
  end

  // clockwise from the top neighbour
  logic [7:0] pattern;
  always_comb begin
    pattern[0] = win_d[1] > win_d[4];
    pattern[1] = win_d[2] > win_d[4];
    pattern[2] = win_d[5] > win_d[4];
    pattern[3] = win_d[8] > win_d[4];
    pattern[4] = win_d[7] > win_d[4];
    pattern[5] = win_d[6] > win_d[4];
    pattern[6] = win_d[3] > win_d[4];
    pattern[7] = win_d[0] > win_d[4];
  end

  // output register
  logic [ulbp_pkg::CODE_W-1:0] code_q;
  logic [QW-1:0]               orow_q, ocol_q;
  logic                        olast_q;
  logic                        out_load;

  assign out_load = s1_adv && s1_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (code_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      code_q  <= ulbp_pkg::uniform_index(pattern);
      orow_q  <= s1_row_q;
      ocol_q  <= s1_col_q;
      olast_q <= s1_last_q;
    end
  end

  assign code_o.valid      = out_valid_q;
  assign code_o.lbp_code   = code_q;
  assign code_o.center_row = orow_q;
  assign code_o.center_col = ocol_q;
  assign code_o.frame_last = olast_q;

  // a forwarded read always belongs to an item in stage 1
  assert property (@(posedge clk_i) disable iff (!rst_ni) fwd_hit_q |-> s1_valid_q)
    else $error("forwarding flag set with stage 1 empty");

  // a blocked result in stage 1 must hold off new pixels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_res_q && out_valid_q && !code_o.ready) |-> !pix_i.ready)
    else $error("pixel taken while stage 1 result is blocked");

  // a result only enters the output register from a valid stage 1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && s1_res_q))
    else $error("output valid without a stage 1 result");

  // codes stay inside the 59 bins
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (code_q <= ulbp_pkg::NON_UNIFORM))
    else $error("code outside the bin range");

endmodule
